/* design/dead_reckoning_integrator_defines.svh */
// assertion macros shared by the dead reckoning integrator rtl
`ifndef DEAD_RECKONING_INTEGRATOR_DEFINES_SVH
`define DEAD_RECKONING_INTEGRATOR_DEFINES_SVH

`ifndef SYNTHESIS
// concurrent check on an explicit clock and active-low reset
`define DRI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same check on the block clock and reset
`define DRI_ASSERT_CLK(lbl, prop, msg) \
  `DRI_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`else
`define DRI_ASSERT(lbl, clk, rst_n, prop, msg)
`define DRI_ASSERT_CLK(lbl, prop, msg)
`endif

`endif

/* design/dri_pkg.sv */
// shared types and constants of the dead reckoning integrator
package dri_pkg;

  // axes that are integrated, and axes carried on the result
  localparam int unsigned AXES         = 3;
  localparam int unsigned NUM_AXES_OUT = 3;
  localparam int unsigned AXIS_W       = $clog2(NUM_AXES_OUT);

  localparam int unsigned DT_W    = 16;
  localparam int unsigned ACCEL_W = 24;
  localparam int unsigned VEL_W   = 48;
  localparam int unsigned POS_W   = 64;
  localparam int unsigned AD_W    = ACCEL_W + DT_W;
  localparam int unsigned TIME_W  = 32;

  // operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_FIX    = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;

  // configuration register index and reset value
  localparam logic       REG_MAX_STEP    = 1'b0;
  localparam logic [15:0] MAX_STEP_RESET = 16'd500;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [TIME_W-1:0]         time_ms;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic signed [POS_W-1:0]   fix_x;
    logic signed [POS_W-1:0]   fix_y;
    logic signed [POS_W-1:0]   fix_z;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic                    integrated;
  } out_t;

endpackage

/* design/dri_mul.sv */
// shared registered multiplier: signed 48 bit times unsigned 16 bit
module dri_mul
  import dri_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [VEL_W-1:0] a_i,
  input  logic [DT_W-1:0]         b_i,
  output logic signed [POS_W-1:0] prod_o
);

  logic signed [VEL_W+DT_W:0] full;
  logic signed [POS_W-1:0]    prod_q;

  // product of a signed and an unsigned operand, fits in 64 bits
  assign full = a_i * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    prod_q <= full[POS_W-1:0];
  end

  assign prod_o = prod_q;

endmodule

/* design/dri_core.sv */
// sequencer and estimate state of the dead reckoning integrator
`include "dead_reckoning_integrator_defines.svh"

module dri_core
  import dri_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DT_W-1:0]  max_step_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output out_t             res_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL_AD  = 3'd1;
  localparam logic [2:0] S_MUL_ADT = 3'd2;
  localparam logic [2:0] S_MUL_VD  = 3'd3;
  localparam logic [2:0] S_ACC     = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

  logic [2:0]                state_q, state_d;
  logic [AXIS_W-1:0]         axis_q;
  logic [DT_W-1:0]           dt_q;
  logic signed [ACCEL_W-1:0] accel_q [NUM_AXES_OUT];
  logic signed [AD_W-1:0]    ad_q;
  logic signed [POS_W-1:0]   half_q;
  logic                      integ_q;
  logic                      started_q;
  logic [TIME_W-1:0]         last_time_q;
  logic signed [POS_W-1:0]   pos_q [NUM_AXES_OUT];
  logic signed [VEL_W-1:0]   vel_q [NUM_AXES_OUT];

  logic                      accept;
  logic [TIME_W-1:0]         dt_full;
  logic                      step_ok;
  logic signed [VEL_W-1:0]   mul_a;
  logic signed [POS_W-1:0]   prod;
  logic signed [POS_W+1:0]   pos_sum;
  logic signed [VEL_W:0]     vel_sum;
  logic signed [POS_W-1:0]   pos_new;
  logic signed [VEL_W-1:0]   vel_new;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // step since the last sample, wrapping
  assign dt_full = in_i.time_ms - last_time_q;
  assign step_ok = (dt_full != '0) && (dt_full <= {{(TIME_W-DT_W){1'b0}}, max_step_i});

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    unique case (state_q)
      S_MUL_AD:  mul_a = {{(VEL_W-ACCEL_W){accel_q[axis_q][ACCEL_W-1]}}, accel_q[axis_q]};
      S_MUL_ADT: mul_a = prod[VEL_W-1:0];
      S_MUL_VD:  mul_a = vel_q[axis_q];
      default:   mul_a = '0;
    endcase
  end

  dri_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (dt_q),
    .prod_o (prod)
  );

  // exact sums with saturation; prod holds vel*dt during accumulate
  assign pos_sum = {{2{pos_q[axis_q][POS_W-1]}}, pos_q[axis_q]}
                 + {{2{prod[POS_W-1]}}, prod}
                 + {{2{half_q[POS_W-1]}}, half_q};
  assign vel_sum = {vel_q[axis_q][VEL_W-1], vel_q[axis_q]}
                 + {{(VEL_W+1-AD_W){ad_q[AD_W-1]}}, ad_q};

  always_comb begin
    if (pos_sum[POS_W+1:POS_W-1] == 3'b000 || pos_sum[POS_W+1:POS_W-1] == 3'b111) begin
      pos_new = pos_sum[POS_W-1:0];
    end else if (pos_sum[POS_W+1]) begin
      pos_new = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_new = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_comb begin
    if (vel_sum[VEL_W] == vel_sum[VEL_W-1]) begin
      vel_new = vel_sum[VEL_W-1:0];
    end else if (vel_sum[VEL_W]) begin
      vel_new = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      vel_new = {1'b0, {(VEL_W-1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.opcode == OP_SAMPLE && started_q && step_ok) begin
            state_d = S_MUL_AD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MUL_AD:  state_d = S_MUL_ADT;
      S_MUL_ADT: state_d = S_MUL_VD;
      S_MUL_VD:  state_d = S_ACC;
      S_ACC:     state_d = (axis_q == LAST_AXIS) ? S_DONE : S_MUL_AD;
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // control and estimate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      integ_q     <= 1'b0;
      started_q   <= 1'b0;
      last_time_q <= '0;
      for (int i = 0; i < NUM_AXES_OUT; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (accept) begin
        axis_q  <= '0;
        integ_q <= (in_i.opcode == OP_SAMPLE) && started_q && step_ok;
        unique case (in_i.opcode)
          OP_SAMPLE: begin
            last_time_q <= in_i.time_ms;
            started_q   <= 1'b1;
          end
          OP_FIX: begin
            for (int i = 0; i < AXES; i++) begin
              pos_q[i] <= (i == 0) ? in_i.fix_x : (i == 1) ? in_i.fix_y : in_i.fix_z;
            end
          end
          OP_RESET: begin
            last_time_q <= '0;
            started_q   <= 1'b0;
            for (int i = 0; i < NUM_AXES_OUT; i++) begin
              pos_q[i] <= '0;
              vel_q[i] <= '0;
            end
          end
          default: ;
        endcase
      end else if (state_q == S_ACC) begin
        pos_q[axis_q] <= pos_new;
        vel_q[axis_q] <= vel_new;
        if (axis_q != LAST_AXIS) begin
          axis_q <= axis_q + 1'b1;
        end
      end
    end
  end

  // operands and intermediate products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q       <= dt_full[DT_W-1:0];
      accel_q[0] <= in_i.accel_x;
      accel_q[1] <= in_i.accel_y;
      accel_q[2] <= in_i.accel_z;
    end
    if (state_q == S_MUL_ADT) begin
      ad_q <= prod[AD_W-1:0];
    end
    if (state_q == S_MUL_VD) begin
      half_q <= prod >>> 1;
    end
  end

  // result of the finished transaction
  assign res_valid_o      = (state_q == S_DONE);
  assign res_o.pos_x      = pos_q[0];
  assign res_o.pos_y      = pos_q[1];
  assign res_o.pos_z      = pos_q[2];
  assign res_o.vel_x      = vel_q[0];
  assign res_o.vel_y      = vel_q[1];
  assign res_o.vel_z      = vel_q[2];
  assign res_o.integrated = integ_q;

  // checks
  `DRI_ASSERT_CLK(a_axis_range, axis_q <= LAST_AXIS, "axis counter out of range")
  `DRI_ASSERT_CLK(a_last_axis_done, (state_q == S_ACC && axis_q == LAST_AXIS) |=> state_q == S_DONE,
                  "last axis did not finish the transaction")
  `DRI_ASSERT_CLK(a_accept_leaves_idle, accept |=> state_q != S_IDLE,
                  "accepted transaction left the sequencer idle")
  `DRI_ASSERT(a_started_by_sample, clk_i, rst_ni,
              $rose(started_q) |-> $past(accept && in_i.opcode == OP_SAMPLE),
              "started set without a sample")

endmodule

/* design/dead_reckoning_integrator.sv */
// Three-axis dead reckoning integrator, top level.
// Input channel (in_valid_i/in_ready_o, payload in_i) takes one transaction per item:
// an acceleration sample, an absolute position fix or an estimate reset. Output channel
// (out_valid_o/out_ready_i, payload out_o) returns one estimate per transaction.
// An integrating sample runs four steps per axis on one shared 48x16 multiplier
// (a*dt, a*dt*dt, v*dt, then add and saturate). Fixes, resets, unused opcodes,
// skipped and first samples skip these steps and go straight to the result, so no
// new transaction is taken until the sequencer has finished the current one.
// in_ready_o is high only while the sequencer is idle.
// The result sits in an output register, so the next transaction is accepted while
// it waits; if the receiver stalls and a second result is ready, the sequencer holds
// it and in_ready_o stays low until the output register frees up.
// max_step_ms is written over the APB port at address 0 (reset value 500); the user
// must write it only while the block is idle, which the block itself does not enforce.
// Reset clears position, velocity, last time and the started flag at once.
module dead_reckoning_integrator
  import dri_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o
);

  logic [DT_W-1:0] max_step_q;
  logic            res_valid;
  logic            res_ready;
  out_t            res;
  logic            out_valid_q;
  out_t            out_q;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q <= MAX_STEP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_STEP) begin
      max_step_q <= pwdata[DT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_STEP) ? {{(32-DT_W){1'b0}}, max_step_q} : '0;

  dri_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_step_i  (max_step_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* tb/testbench.sv */
// self-checking testbench for the dead reckoning integrator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dri_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] STEP_ADDR = {REG_MAX_STEP, 2'b00};
  localparam logic signed [ACCEL_W-1:0] ACC_MAX = {1'b0, {(ACCEL_W-1){1'b1}}};
  localparam logic signed [ACCEL_W-1:0] ACC_MIN = {1'b1, {(ACCEL_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // estimate state mirrored by the predictor
  logic signed [POS_W-1:0] est_pos [3] = '{default: '0};
  logic signed [VEL_W-1:0] est_vel [3] = '{default: '0};
  logic [TIME_W-1:0] last_stamp = '0;
  logic stamp_seen = 1'b0;
  logic [15:0] step_limit = MAX_STEP_RESET;

  in_t outgoing_items [$];
  out_t estimate_q [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // sender and receiver pacing
  logic sender_steady = 1'b1;
  logic [15:0] stall_pattern = '0;
  logic long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [TIME_W-1:0] stamp_gen = '0;

  dead_reckoning_integrator uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one transaction through the estimator, returns the estimate it answers with
  function automatic out_t advance_estimate(input in_t item);
    logic [TIME_W-1:0] dt;
    logic signed [ACCEL_W-1:0] acc [3];
    logic signed [POS_W-1:0] fix [3];
    logic signed [127:0] d, ad, pos_sum, vel_sum;
    out_t res;
    res = '0;
    acc = '{item.accel_x, item.accel_y, item.accel_z};
    fix = '{item.fix_x, item.fix_y, item.fix_z};
    case (item.opcode)
      OP_SAMPLE: begin
        if (!stamp_seen) begin
          last_stamp = item.time_ms;
          stamp_seen = 1'b1;
        end else begin
          dt = item.time_ms - last_stamp;
          last_stamp = item.time_ms;
          if (dt != 0 && dt <= step_limit) begin
            d = dt;
            for (int i = 0; i < AXES; i++) begin
              ad = acc[i];
              ad = ad * d;
              // exact position sum, old velocity, floor halving
              pos_sum = est_pos[i];
              pos_sum = pos_sum + est_vel[i] * d + ((ad * d) >>> 1);
              if (pos_sum[127:63] != {65{pos_sum[63]}}) begin
                est_pos[i] = pos_sum[127] ? POS_MIN : POS_MAX;
              end else begin
                est_pos[i] = pos_sum[63:0];
              end
              vel_sum = est_vel[i];
              vel_sum = vel_sum + ad;
              if (vel_sum[127:47] != {81{vel_sum[47]}}) begin
                est_vel[i] = vel_sum[127] ? VEL_MIN : VEL_MAX;
              end else begin
                est_vel[i] = vel_sum[47:0];
              end
            end
            res.integrated = 1'b1;
          end
        end
      end
      OP_FIX: begin
        for (int i = 0; i < AXES; i++) est_pos[i] = fix[i];
      end
      OP_RESET: begin
        est_pos = '{default: '0};
        est_vel = '{default: '0};
        last_stamp = '0;
        stamp_seen = 1'b0;
      end
      default: ;
    endcase
    res.pos_x = est_pos[0];
    res.pos_y = est_pos[1];
    res.pos_z = est_pos[2];
    res.vel_x = est_vel[0];
    res.vel_y = est_vel[1];
    res.vel_z = est_vel[2];
    return res;
  endfunction

  // input driver, bursts with gaps, predicts on every accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) estimate_q.push_back(advance_estimate(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (outgoing_items.size() > 0) begin
          in_data <= outgoing_items.pop_front();
          in_valid <= 1'b1;
          if (!sender_steady) begin
            burst_left--;
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 12);
              gap_left = $urandom_range(1, 8);
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin : receiver
    out_t want;
    logic [2:0][POS_W-1:0] pos_want, pos_got;
    logic [2:0][VEL_W-1:0] vel_want, vel_got;
    string axis_tag [3];
    axis_tag = '{"x", "y", "z"};
    if (rst_n && out_valid && out_ready) begin
      if (estimate_q.size() == 0) begin
        $error("estimate transaction with nothing expected");
        error_count++;
      end else begin
        want = estimate_q.pop_front();
        pos_want = {want.pos_x, want.pos_y, want.pos_z};
        pos_got = {out_data.pos_x, out_data.pos_y, out_data.pos_z};
        vel_want = {want.vel_x, want.vel_y, want.vel_z};
        vel_got = {out_data.vel_x, out_data.vel_y, out_data.vel_z};
        for (int i = 0; i < 3; i++) begin
          if (pos_got[2-i] !== pos_want[2-i]) begin
            $error("pos_%s expected %0d actual %0d", axis_tag[i],
                   $signed(pos_want[2-i]), $signed(pos_got[2-i]));
            error_count++;
          end
          if (vel_got[2-i] !== vel_want[2-i]) begin
            $error("vel_%s expected %0d actual %0d", axis_tag[i],
                   $signed(vel_want[2-i]), $signed(vel_got[2-i]));
            error_count++;
          end
        end
        if (out_data.integrated !== want.integrated) begin
          $error("integrated expected %0d actual %0d", want.integrated,
                 out_data.integrated);
          error_count++;
        end
      end
    end
    // long hold-off on request, else the rotating stall pattern
    if (long_hold_req) begin
      hold_left = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      out_ready <= !stall_pattern[0];
    end
  end

  // every field random, the caller overrides what matters
  function automatic in_t noise_item();
    in_t item;
    item.opcode = 2'($urandom);
    item.time_ms = $urandom;
    item.accel_x = ACCEL_W'($urandom);
    item.accel_y = ACCEL_W'($urandom);
    item.accel_z = ACCEL_W'($urandom);
    item.fix_x = {$urandom, $urandom};
    item.fix_y = {$urandom, $urandom};
    item.fix_z = {$urandom, $urandom};
    return item;
  endfunction

  function automatic in_t sample_at(input logic [TIME_W-1:0] t,
                                    input logic signed [ACCEL_W-1:0] ax, ay, az);
    in_t item;
    item = noise_item();
    item.opcode = OP_SAMPLE;
    item.time_ms = t;
    item.accel_x = ax;
    item.accel_y = ay;
    item.accel_z = az;
    return item;
  endfunction

  function automatic in_t fix_at(input logic signed [POS_W-1:0] x, y, z);
    in_t item;
    item = noise_item();
    item.opcode = OP_FIX;
    item.fix_x = x;
    item.fix_y = y;
    item.fix_z = z;
    return item;
  endfunction

  function automatic in_t control_item(input logic [1:0] op);
    in_t item;
    item = noise_item();
    item.opcode = op;
    return item;
  endfunction

  function automatic logic signed [ACCEL_W-1:0] pick_accel();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) return ACCEL_W'($urandom);
    if (mode < 8) return ACCEL_W'($signed($urandom_range(0, 2000)) - 1000);
    return mode[0] ? ACC_MAX : ACC_MIN;
  endfunction

  function automatic logic signed [POS_W-1:0] pick_position();
    if ($urandom_range(0, 1)) return {$urandom, $urandom};
    return POS_W'($signed($urandom_range(0, 2000000)) - 1000000);
  endfunction

  // mostly well-formed samples with a spread of time steps around the limit
  function automatic in_t random_item(input logic [15:0] lim);
    in_t item;
    int unsigned pick;
    logic [TIME_W-1:0] dt;
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) dt = '0;
      else if (pick < 16) dt = lim + $urandom_range(1, 100);
      else if (pick < 20) dt = $urandom;
      else dt = $urandom_range(1, (lim == 0) ? 1 : lim);
      stamp_gen += dt;
      item = sample_at(stamp_gen, pick_accel(), pick_accel(), pick_accel());
    end else if (pick < 90) begin
      item = fix_at(pick_position(), pick_position(), pick_position());
    end else if (pick < 95) begin
      item = control_item(OP_RESET);
    end else begin
      item = control_item(OP_UNUSED);
    end
    return item;
  endfunction

  // register write then read back, apb setup and access phases
  task automatic write_max_step(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= STEP_ADDR;
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    step_limit = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[15:0] !== value) begin
      $error("max_step_ms expected %0d actual %0d", value, prdata[15:0]);
      error_count++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every transaction is answered and the block has settled
  task automatic drain();
    while (outgoing_items.size() > 0 || in_valid || estimate_q.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic run_random(input logic [15:0] lim, input int unsigned count,
                            input logic with_hold);
    write_max_step(lim);
    @(negedge clk);
    sender_steady = ($urandom_range(0, 3) == 0);
    // keep at least one ready slot in every rotation
    stall_pattern = ($urandom_range(0, 3) == 0) ? 16'h0 : (16'($urandom) & 16'h7FFF);
    stamp_gen = $urandom;
    repeat (count) outgoing_items.push_back(random_item(lim));
    if (with_hold) begin
      repeat (30) @(negedge clk);
      long_hold_req = 1'b1;
    end
    drain();
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] t;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first sample, zero and boundary steps, saturation, wrap, odd halving
    write_max_step(MAX_STEP_RESET);
    @(negedge clk);
    outgoing_items.push_back(sample_at(100, 1, -1, 0));
    outgoing_items.push_back(sample_at(100, 5, 5, 5));
    outgoing_items.push_back(sample_at(101, ACC_MAX, ACC_MIN, 0));
    outgoing_items.push_back(sample_at(601, -3, 7, ACC_MAX));
    outgoing_items.push_back(sample_at(1102, ACC_MAX, ACC_MAX, ACC_MAX));
    outgoing_items.push_back(control_item(OP_UNUSED));
    outgoing_items.push_back(fix_at(POS_MAX, POS_MIN, 0));
    outgoing_items.push_back(sample_at(1602, ACC_MAX, ACC_MIN, 5));
    outgoing_items.push_back(fix_at(POS_MIN, POS_MAX, -1));
    outgoing_items.push_back(sample_at(2102, ACC_MIN, ACC_MAX, -5));
    outgoing_items.push_back(control_item(OP_RESET));
    outgoing_items.push_back(sample_at(32'hFFFF_FFF0, 9, 9, 9));
    outgoing_items.push_back(sample_at(32'h0000_0010, ACC_MAX, ACC_MAX, ACC_MAX));
    outgoing_items.push_back(sample_at(32'h8000_0010, 1, 1, 1));
    outgoing_items.push_back(sample_at(32'h8000_0011, -1, -1, -1));
    outgoing_items.push_back(sample_at(32'h8000_0014, 1, -1, 3));
    outgoing_items.push_back(fix_at({$urandom, $urandom}, {$urandom, $urandom}, 0));
    outgoing_items.push_back(sample_at(32'h8000_0015, -7, 0, 7));
    outgoing_items.push_back(control_item(OP_RESET));
    outgoing_items.push_back(control_item(OP_UNUSED));
    drain();

    // widest step: drive velocity and position into saturation on both sides
    write_max_step(16'hFFFF);
    @(negedge clk);
    sender_steady = 1'b0;
    stall_pattern = 16'($urandom) & 16'h7FFF;
    outgoing_items.push_back(control_item(OP_RESET));
    t = $urandom;
    repeat (300) begin
      t += 32'd65535;
      outgoing_items.push_back(sample_at(t, ACC_MAX, ACC_MIN, pick_accel()));
    end
    drain();

    // random phases over several step limits, one with a long receiver hold-off
    run_random(16'd0, 100, 1'b0);
    run_random(16'd1, 250, 1'b0);
    run_random(16'($urandom_range(2, 2000)), 300, 1'b1);
    run_random(16'($urandom), 300, 1'b0);
    run_random(16'hFFFF, 300, 1'b0);

    repeat (30) @(posedge clk);
    if (error_count == 0 && estimate_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* dead_reckoning_integrator.f */
+incdir+design
design/dri_pkg.sv
design/dri_mul.sv
design/dri_core.sv
design/dead_reckoning_integrator.sv
tb/testbench.sv
